>>> sv/scpd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// scpd_pkg
// Shared types and constants for the sync/checksum packet deframer.
// ============================================================================
package scpd_pkg;

    // Default number of 16-bit channel words per packet.
    localparam int CHANNEL_COUNT_DEF = 8;

    // Field widths fixed by the packet format.
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 16;
    localparam int CHAN_IDX_W = 3;

    // Sync byte value after reset.
    localparam logic [BYTE_W-1:0] SYNC_RESET = 8'h80;

    typedef logic [BYTE_W-1:0] t_byte;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        ST_HUNT    = 6'b000001,
        ST_PAYLOAD = 6'b000010,
        ST_CHECK   = 6'b000100,
        ST_READ_HI = 6'b001000,
        ST_READ_LO = 6'b010000,
        ST_EMIT    = 6'b100000
    } t_state;

endpackage

>>> sv/scpd_ifs.sv
`timescale 1ns / 1ps
// ============================================================================
// scpd_ifs
// Valid/ready channel interfaces for the deframer: received bytes, channel
// words and sync value configuration writes.
// ============================================================================

interface scpd_byte_if
    import scpd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface scpd_word_if
    import scpd_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CHAN_IDX_W-1:0] channel_index;
    logic [WORD_W-1:0]     channel_value;
    logic                  last_word;

    modport source (output valid, output channel_index, output channel_value,
                    output last_word, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_word, output ready);
endinterface

interface scpd_cfg_if
    import scpd_pkg::*;
;
    logic  valid;
    logic  ready;
    t_byte sync_value;

    modport source (output valid, output sync_value, input ready);
    modport sink   (input valid, input sync_value, output ready);
endinterface

>>> sv/scpd_payload_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// scpd_payload_ram
// Payload byte store: one write port, one read port with registered data.
// ============================================================================
module scpd_payload_ram
    import scpd_pkg::*;
#(
    parameter int DEPTH  = 2 * CHANNEL_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_byte             i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_byte             o_rdata
);

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/scpd_seq.sv
`timescale 1ns / 1ps
// ============================================================================
// scpd_seq
// Framing sequencer: sync hunt, payload capture with running sum, checksum
// test and word-by-word readout of the payload store into an output register.
// ============================================================================
module scpd_seq
    import scpd_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int ADDR_W        = $clog2(2 * CHANNEL_COUNT)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Received bytes
    input  logic                  i_in_valid,
    input  t_byte                 i_in_byte,
    output logic                  o_in_ready,
    // Sync value register
    input  t_byte                 i_sync_value,
    // Payload store
    output logic                  o_ram_we,
    output logic [ADDR_W-1:0]     o_ram_waddr,
    output logic                  o_ram_re,
    output logic [ADDR_W-1:0]     o_ram_raddr,
    input  t_byte                 i_ram_rdata,
    // Channel words
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [CHAN_IDX_W-1:0] o_out_index,
    output logic [WORD_W-1:0]     o_out_value,
    output logic                  o_out_last
);

    localparam int CHAN_W = ($clog2(CHANNEL_COUNT) > CHAN_IDX_W) ?
                            $clog2(CHANNEL_COUNT) : CHAN_IDX_W;
    localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(2 * CHANNEL_COUNT - 1);
    localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNEL_COUNT - 1);

    t_state              r_state,   n_state;
    logic [ADDR_W-1:0]   r_pos,     n_pos;
    logic [ADDR_W-1:0]   r_rd_addr, n_rd_addr;
    t_byte               r_sum,     n_sum;
    logic [CHAN_W-1:0]   r_chan,    n_chan;
    logic                r_out_valid, n_out_valid;
    t_byte               r_hi,      n_hi;
    logic [CHAN_IDX_W-1:0] r_out_index, n_out_index;
    logic [WORD_W-1:0]   r_out_value, n_out_value;
    logic                r_out_last,  n_out_last;

    logic in_fire;
    logic out_free;

    assign o_in_ready = (r_state == ST_HUNT) || (r_state == ST_PAYLOAD) ||
                        (r_state == ST_CHECK);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_rd_addr   = r_rd_addr;
        n_sum       = r_sum;
        n_chan      = r_chan;
        n_hi        = r_hi;
        n_out_index = r_out_index;
        n_out_value = r_out_value;
        n_out_last  = r_out_last;
        n_out_valid = r_out_valid && !i_out_ready;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;

        case (r_state)
            ST_HUNT: begin
                if (in_fire && (i_in_byte == i_sync_value)) begin
                    n_state = ST_PAYLOAD;
                    n_pos   = '0;
                    n_sum   = '0;
                end
            end
            ST_PAYLOAD: begin
                if (in_fire) begin
                    o_ram_we = 1'b1;
                    n_sum    = r_sum + i_in_byte;
                    if (r_pos == LAST_POS) begin
                        n_pos   = '0;
                        n_state = ST_CHECK;
                    end else begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            ST_CHECK: begin
                if (in_fire) begin
                    n_sum = '0;
                    if (i_in_byte == r_sum) begin
                        n_state   = ST_READ_HI;
                        n_rd_addr = '0;
                        n_chan    = '0;
                    end else begin
                        n_state = ST_HUNT;
                    end
                end
            end
            ST_READ_HI: begin
                o_ram_re  = 1'b1;
                n_rd_addr = r_rd_addr + 1'b1;
                n_state   = ST_READ_LO;
            end
            ST_READ_LO: begin
                // The high byte read in the previous cycle is on the read port now.
                o_ram_re  = 1'b1;
                n_rd_addr = r_rd_addr + 1'b1;
                n_hi      = i_ram_rdata;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_index = r_chan[CHAN_IDX_W-1:0];
                    n_out_value = {r_hi, i_ram_rdata};
                    n_out_last  = (r_chan == LAST_CHAN);
                    if (r_chan == LAST_CHAN) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_state = ST_READ_HI;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_HUNT;
            r_pos       <= '0;
            r_rd_addr   <= '0;
            r_sum       <= '0;
            r_chan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_rd_addr   <= n_rd_addr;
            r_sum       <= n_sum;
            r_chan      <= n_chan;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi        <= n_hi;
        r_out_index <= n_out_index;
        r_out_value <= n_out_value;
        r_out_last  <= n_out_last;
    end

    assign o_ram_waddr = r_pos;
    assign o_ram_raddr = r_rd_addr;
    assign o_out_valid = r_out_valid;
    assign o_out_index = r_out_index;
    assign o_out_value = r_out_value;
    assign o_out_last  = r_out_last;

endmodule

>>> sv/sync_checksum_packet_deframer.sv
`timescale 1ns / 1ps
// ============================================================================
// sync_checksum_packet_deframer
// Hunts for a sync byte, captures 2*CHANNEL_COUNT payload bytes and a
// checksum byte, and on a good checksum emits CHANNEL_COUNT big-endian words.
// ============================================================================
// Throughput: one received byte is taken per cycle while hunting or framing.
// Each word passes the read-high, read-low and emit states: two payload store
// reads, then the emit registers the word once the output register is free.
// The input is held off for the whole burst, including any output stall.
// A bad checksum returns straight to hunting. Reset (synchronous, active low)
// returns to hunting and sets the sync value to 0x80; the store is kept.
// ============================================================================
module sync_checksum_packet_deframer
    import scpd_pkg::*;
#(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    scpd_byte_if.sink          i_rx,
    scpd_cfg_if.sink           i_cfg,
    scpd_word_if.source        o_word
);

    // Payload store holds two bytes per channel word.
    localparam int DEPTH  = 2 * CHANNEL_COUNT;
    localparam int ADDR_W = $clog2(DEPTH);

    // The sync value register. The user must write it only while the block is
    // idle; the block itself does not enforce this. The port can always take a transfer.
    t_byte r_sync_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value <= SYNC_RESET;
        end else if (i_cfg.valid) begin
            r_sync_value <= i_cfg.sync_value;
        end
    end

    assign i_cfg.ready = 1'b1;

    // Connections between the sequencer and the payload store.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    t_byte             ram_rdata;

    // Payload bytes are written in arrival order and read back pairwise,
    // high byte first, to build each channel word.
    scpd_payload_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_rx.rx_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The sequencer owns the framing state, the running sum and the output
    // register, so a finished word can wait for the sink while the next read
    // from the store is already under way.
    scpd_seq #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .ADDR_W        (ADDR_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_rx.valid),
        .i_in_byte    (i_rx.rx_byte),
        .o_in_ready   (i_rx.ready),
        .i_sync_value (r_sync_value),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_re     (ram_re),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata),
        .o_out_valid  (o_word.valid),
        .i_out_ready  (o_word.ready),
        .o_out_index  (o_word.channel_index),
        .o_out_value  (o_word.channel_value),
        .o_out_last   (o_word.last_word)
    );

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the sync/checksum packet deframer. Received bytes
// are fed through the byte channel with random gaps. A model of the framing
// logic predicts the channel words that each good packet produces. A checker
// compares every word transfer on the output channel, field by field,
// against the oldest prediction while the output side stalls at random.
// ============================================================================
module tb;
    import scpd_pkg::*;

    localparam int N_CH          = CHANNEL_COUNT_DEF;
    localparam int PAYLOAD_BYTES = 2 * N_CH;
    // Settling wait that the bench adds on top of the drain before a sync value
    // write, long enough for one output burst.
    localparam int DRAIN_CYCLES  = 3 * N_CH + 8;

    // Framing phases of the bench's own model.
    typedef enum logic [1:0] {
        HUNTING,
        IN_PAYLOAD,
        AT_CHECKSUM
    } t_frame_phase;

    typedef struct packed {
        logic [CHAN_IDX_W-1:0] idx;
        logic [WORD_W-1:0]     value;
        logic                  last;
    } t_chan_word;

    typedef t_byte t_payload [PAYLOAD_BYTES];

    logic i_clk = 1'b0;
    logic i_rst_n;

    scpd_byte_if rx_if ();
    scpd_cfg_if  cfg_if ();
    scpd_word_if word_if ();

    sync_checksum_packet_deframer #(
        .CHANNEL_COUNT (N_CH)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_word  (word_if)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Framing model. It tracks the sync value, the framing phase, the payload
    // bytes and the running checksum exactly as the block should.
    // ------------------------------------------------------------------------
    t_byte        sync_model   = SYNC_RESET;
    t_frame_phase rx_phase     = HUNTING;
    int           byte_pos     = 0;
    t_byte        payload_copy [PAYLOAD_BYTES];
    t_byte        payload_sum  = '0;

    // Channel words predicted but not yet seen on the output channel.
    t_chan_word   expected_words [$];

    // Run statistics and error tally.
    int error_count    = 0;
    int bytes_sent     = 0;
    int packets_sent   = 0;
    int words_checked  = 0;
    int sync_writes    = 0;

    // When clear, neither side of the bench inserts idle cycles.
    bit idling_on      = 1'b1;
    int stall_left     = 0;

    // Advances the model by one accepted byte and queues any words that the
    // byte releases.
    function automatic void predict_rx_byte(input t_byte b);
        t_chan_word w;
        case (rx_phase)
            IN_PAYLOAD: begin
                payload_copy[byte_pos] = b;
                payload_sum            = payload_sum + b;
                byte_pos++;
                if (byte_pos >= PAYLOAD_BYTES) begin
                    byte_pos = 0;
                    rx_phase = AT_CHECKSUM;
                end
            end
            AT_CHECKSUM: begin
                // A matching checksum releases one word per byte pair, high
                // byte first. A mismatch drops the packet silently. Either
                // way the payload is not rescanned for a sync byte.
                if (b == payload_sum) begin
                    for (int k = 0; k < N_CH; k++) begin
                        w.idx   = k[CHAN_IDX_W-1:0];
                        w.value = {payload_copy[2*k], payload_copy[2*k+1]};
                        w.last  = (k == N_CH - 1);
                        expected_words.push_back(w);
                    end
                end
                rx_phase    = HUNTING;
                byte_pos    = 0;
                payload_sum = '0;
            end
            default: begin
                if (b == sync_model) begin
                    rx_phase    = IN_PAYLOAD;
                    byte_pos    = 0;
                    payload_sum = '0;
                end
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Output side: random stall bursts on ready while idling is on.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_if.ready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            word_if.ready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            word_if.ready <= 1'b0;
            stall_left    <= $urandom_range(0, 3);
        end else begin
            word_if.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Word checker. Every transfer on the output channel is matched against
    // the oldest predicted word. Values are sampled at the edge, before any
    // update scheduled for that edge takes effect.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : word_check
        t_chan_word want;
        if (i_rst_n === 1'b1 && word_if.valid === 1'b1 && word_if.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
                $error("unexpected channel word: channel_index %0d channel_value %h",
                       word_if.channel_index, word_if.channel_value);
                error_count++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                if (word_if.channel_index !== want.idx) begin
                    $error("channel_index: expected %0d, actual %0d",
                           want.idx, word_if.channel_index);
                    error_count++;
                end
                if (word_if.channel_value !== want.value) begin
                    $error("channel_value: expected %h, actual %h",
                           want.value, word_if.channel_value);
                    error_count++;
                end
                if (word_if.last_word !== want.last) begin
                    $error("last_word: expected %0d, actual %0d",
                           want.last, word_if.last_word);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Byte sender. It is called just after the clock rises, so every drive
    // below is in step with the rising clock. When the caller sends back to back
    // the valid line simply stays high.
    // ------------------------------------------------------------------------
    task automatic send_byte(input t_byte b);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (rx_if.ready !== 1'b1);
        predict_rx_byte(b);
        bytes_sent++;
    endtask

    // Sends the sync byte, the payload and a checksum that either matches the
    // payload sum or is deliberately off by a nonzero amount.
    task automatic send_packet(input t_payload pl, input bit good);
        t_byte sum = '0;
        t_byte chk;
        foreach (pl[i]) sum = sum + pl[i];
        chk = good ? sum : (sum ^ t_byte'($urandom_range(1, 255)));
        send_byte(sync_model);
        foreach (pl[i]) send_byte(pl[i]);
        send_byte(chk);
        packets_sent++;
    endtask

    // Drops valid and waits until every predicted word has been seen, then
    // lets the block settle for the length of one output burst.
    task automatic wait_drained();
        rx_if.valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes a new sync value. Any partial frame is completed with filler
    // bytes first so that the block is hunting and idle at the write.
    task automatic write_sync(input t_byte v);
        while (rx_phase != HUNTING) send_byte(t_byte'($urandom_range(0, 255)));
        wait_drained();
        cfg_if.valid      <= 1'b1;
        cfg_if.sync_value <= v;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        cfg_if.valid      <= 1'b0;
        sync_model = v;
        sync_writes++;
    endtask

    function automatic t_payload random_payload();
        t_payload pl;
        foreach (pl[i]) pl[i] = t_byte'($urandom_range(0, 255));
        return pl;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset sync value, extreme payload bytes, a sync byte inside the payload
    // and as a bad checksum, and a clean packet right after a dropped one.
    task automatic test_directed();
        t_payload pl;
        // Bytes that do not match the sync value are discarded while hunting.
        send_byte(8'h00);
        send_byte(8'hFF);
        // Alternating full-scale and zero bytes, plus a pair equal to the
        // sync value, which must be taken as plain data.
        foreach (pl[i]) pl[i] = (i < PAYLOAD_BYTES / 2) ? ((i % 2) ? 8'h00 : 8'hFF)
                                                         : ((i % 2) ? 8'hFF : 8'h00);
        pl[6] = SYNC_RESET;
        pl[7] = SYNC_RESET;
        send_packet(pl, 1'b1);
        // All bytes full scale with the sync value as a wrong checksum.
        foreach (pl[i]) pl[i] = 8'hFF;
        send_byte(sync_model);
        foreach (pl[i]) send_byte(pl[i]);
        send_byte(SYNC_RESET);
        packets_sent++;
        // The next packet must frame normally after the dropped one.
        foreach (pl[i]) pl[i] = 8'h00;
        send_packet(pl, 1'b1);
        wait_drained();
    endtask

    // Sync values at both ends of the byte range.
    task automatic test_sync_extremes();
        write_sync(8'hFF);
        send_byte(8'h80);
        send_packet(random_payload(), 1'b1);
        write_sync(8'h00);
        send_byte(8'hFF);
        send_byte(8'h01);
        send_packet(random_payload(), 1'b1);
        send_packet(random_payload(), 1'b0);
        wait_drained();
    endtask

    // Mostly well-formed packets with random content, mixed with noise,
    // bad checksums and truncated frames, under a fresh random sync value.
    task automatic test_random(input int n_bytes, input bit with_idling);
        int    start;
        int    pick;
        t_byte b;
        idling_on = with_idling;
        write_sync(t_byte'($urandom_range(0, 255)));
        start = bytes_sent;
        while (bytes_sent - start < n_bytes) begin
            repeat ($urandom_range(0, 2)) begin
                b = t_byte'($urandom_range(0, 255));
                if (b == sync_model && $urandom_range(0, 3) != 0) b = ~b;
                send_byte(b);
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_packet(random_payload(), 1'b1);
            end else if (pick < 9) begin
                send_packet(random_payload(), 1'b0);
            end else begin
                // A truncated frame: the next packet's bytes are absorbed as
                // payload, exactly as the framing rules dictate.
                send_byte(sync_model);
                repeat ($urandom_range(1, PAYLOAD_BYTES - 1))
                    send_byte(t_byte'($urandom_range(0, 255)));
            end
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        rx_if.valid       <= 1'b0;
        rx_if.rx_byte     <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.sync_value <= '0;
        i_rst_n           <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_sync_extremes();
        test_random(12, 1'b1);
        test_random(12, 1'b1);
        test_random(12, 1'b1);
        // The last stretch runs with no idling on either side.
        test_random(12, 1'b0);

        while (rx_phase != HUNTING) send_byte(t_byte'($urandom_range(0, 255)));
        wait_drained();

        $display("Covered %0d received bytes in %0d packets under %0d sync writes.",
                 bytes_sent, packets_sent, sync_writes);
        $display("Checked %0d channel words, %0d errors.", words_checked, error_count);
        if (error_count == 0 && expected_words.size() == 0) begin
            $display("sync_checksum_packet_deframer regression: pass");
        end else begin
            $display("sync_checksum_packet_deframer regression: fail");
        end
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #2_000_000;
        $display("sync_checksum_packet_deframer regression: fail");
        $finish;
    end

endmodule
